### rtl/core/percent_utf8_decoder_macros.svh
// Assertion macros for the percent/UTF-8 decoder checker.
`ifndef PERCENT_UTF8_DECODER_MACROS_SVH
`define PERCENT_UTF8_DECODER_MACROS_SVH

// Checked only outside reset.
`define PUD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PUD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/pud_pkg.sv
`timescale 1ns / 1ps

package pud_pkg;

	localparam int CP_W = 21;
	localparam logic [7:0] PERCENT_CHAR = 8'h25;
	localparam logic [CP_W-1:0] UNICODE_MAX = 21'h10FFFF;
	localparam logic [CP_W-1:0] MAX_CP_RESET = UNICODE_MAX;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_HI,
		ESC_LO
	} esc_phase_t;

	typedef struct packed {
		esc_phase_t      escape_phase;
		logic [3:0]      high_nibble;
		logic [CP_W-1:0] char_accum;
		logic [1:0]      bytes_pending;
		logic [1:0]      seq_length;
	} dec_state_t;

	typedef struct packed {
		logic            valid;
		logic            is_error;
		logic [CP_W-1:0] code_point;
	} dec_result_t;

	// {bad, value}; bad set when c is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

### rtl/core/pud_step.sv
`timescale 1ns / 1ps

module pud_step (
	input  pud_pkg::dec_state_t            st,
	input  logic [7:0]                     enc_byte,
	input  logic                           is_last,
	input  logic [pud_pkg::CP_W-1:0]       max_cp,
	output pud_pkg::dec_state_t            st_nxt,
	output pud_pkg::dec_result_t           res
);

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_CP,
		KIND_ERR
	} kind_t;

	kind_t                      kind;
	pud_pkg::dec_state_t        nxt;
	logic [4:0]                 hex;
	logic                       do_utf;
	logic [7:0]                 raw;
	logic [pud_pkg::CP_W-1:0]   v;
	logic                       check_range;

	always_comb begin
		nxt         = st;
		kind        = KIND_NONE;
		do_utf      = 1'b0;
		raw         = enc_byte;
		v           = '0;
		check_range = 1'b0;
		hex         = pud_pkg::hex_value(enc_byte);

		unique case (st.escape_phase)
			pud_pkg::ESC_NONE: begin
				if (enc_byte == pud_pkg::PERCENT_CHAR) begin
					nxt.escape_phase = pud_pkg::ESC_HI;
				end else begin
					do_utf = 1'b1;
				end
			end
			pud_pkg::ESC_HI: begin
				if (hex[4]) begin
					kind = KIND_ERR;
				end else begin
					nxt.high_nibble  = hex[3:0];
					nxt.escape_phase = pud_pkg::ESC_LO;
				end
			end
			pud_pkg::ESC_LO: begin
				if (hex[4]) begin
					kind = KIND_ERR;
				end else begin
					nxt.escape_phase = pud_pkg::ESC_NONE;
					nxt.high_nibble  = 4'd0;
					raw              = {st.high_nibble, hex[3:0]};
					do_utf           = 1'b1;
				end
			end
			default: begin
				kind = KIND_ERR;
			end
		endcase

		if (do_utf) begin
			if (st.bytes_pending == 2'd0) begin
				if (raw < 8'h80) begin
					v           = {13'd0, raw};
					check_range = 1'b1;
				end else if (raw >= 8'hC2 && raw <= 8'hDF) begin
					nxt.char_accum    = {16'd0, raw[4:0]};
					nxt.bytes_pending = 2'd1;
					nxt.seq_length    = 2'd1;
				end else if (raw >= 8'hE0 && raw <= 8'hEF) begin
					nxt.char_accum    = {17'd0, raw[3:0]};
					nxt.bytes_pending = 2'd2;
					nxt.seq_length    = 2'd2;
				end else if (raw >= 8'hF0 && raw <= 8'hF4) begin
					nxt.char_accum    = {18'd0, raw[2:0]};
					nxt.bytes_pending = 2'd3;
					nxt.seq_length    = 2'd3;
				end else begin
					kind = KIND_ERR;
				end
			end else if (raw[7:6] != 2'b10) begin
				kind = KIND_ERR;
			end else begin
				v                 = {st.char_accum[14:0], raw[5:0]};
				nxt.char_accum    = v;
				nxt.bytes_pending = st.bytes_pending - 2'd1;
				if (nxt.bytes_pending == 2'd0) begin
					// overlong forms and surrogates
					if ((st.seq_length == 2'd1 && v < 21'h80) ||
					    (st.seq_length == 2'd2 && v < 21'h800) ||
					    (st.seq_length == 2'd3 && v < 21'h10000) ||
					    (v >= 21'hD800 && v <= 21'hDFFF)) begin
						kind = KIND_ERR;
					end else begin
						nxt.char_accum = '0;
						nxt.seq_length = 2'd0;
						check_range    = 1'b1;
					end
				end
			end
		end

		if (check_range) begin
			if (v > pud_pkg::UNICODE_MAX || v > max_cp) begin
				kind = KIND_ERR;
			end else begin
				kind = KIND_CP;
			end
		end

		// string ends inside an escape or a sequence
		if (kind == KIND_NONE && is_last &&
		    (nxt.escape_phase != pud_pkg::ESC_NONE || nxt.bytes_pending != 2'd0)) begin
			kind = KIND_ERR;
		end

		if (kind == KIND_ERR || is_last) begin
			nxt = '0;
		end

		st_nxt         = nxt;
		res.valid      = (kind != KIND_NONE);
		res.is_error   = (kind == KIND_ERR);
		res.code_point = (kind == KIND_CP) ? v : '0;
	end

endmodule

### rtl/core/percent_utf8_decoder.sv
`timescale 1ns / 1ps
// Percent/UTF-8 decoder: takes one byte of a URL-encoded string per transaction
// (tlast on the final byte), undoes %XX escapes and decodes the raw bytes as
// UTF-8, giving at most one result per byte: a code point, or an error (code
// point 0) for bad hex, a bad or overlong UTF-8 sequence, a surrogate, a value
// above 0x10FFFF or max_code_point, or an escape or sequence open at tlast.
// Bytes that only advance an escape or a sequence give no result. A byte is
// registered, decoded combinationally against the decoder state and lands in
// the result register; one byte is taken every cycle while m_axis_tready keeps
// up, and a stalled result holds the input stage. Write max_code_point only
// while no transaction is in flight.

module percent_utf8_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [20:0] cfg_data,       // max_code_point
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] enc_byte
	input  logic        s_axis_tlast,   // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] code_point, [21] is_error, [23:22] zero
	output logic        m_axis_tlast    // last_out
);

	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	logic                       last_s1;
	logic                       fire_s1;
	logic [pud_pkg::CP_W-1:0]   max_cp_q;
	pud_pkg::dec_state_t        st_q;
	pud_pkg::dec_state_t        st_nxt;
	pud_pkg::dec_result_t       res;
	logic                       out_valid_q;
	logic [pud_pkg::CP_W-1:0]   out_cp_q;
	logic                       out_err_q;
	logic                       out_last_q;

	assign cfg_ready     = 1'b1;
	assign fire_s1       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cp_q <= pud_pkg::MAX_CP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_cp_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	pud_step u_step (
		.st       (st_q),
		.enc_byte (byte_s1),
		.is_last  (last_s1),
		.max_cp   (max_cp_q),
		.st_nxt   (st_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				st_q <= st_nxt;
			end
			if (fire_s1 && res.valid) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res.valid) begin
			out_cp_q   <= res.code_point;
			out_err_q  <= res.is_error;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_err_q, out_cp_q};
	assign m_axis_tlast  = out_last_q;

endmodule

### rtl/core/pud_checker.sv
`timescale 1ns / 1ps
`include "percent_utf8_decoder_macros.svh"

module pud_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	`PUD_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !m_axis_tvalid,
		"result valid during reset")

	`PUD_ASSERT(a_err_zero_cp,
		m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[20:0] == 21'd0,
		"error result with nonzero code point")

	`PUD_ASSERT(a_cp_legal,
		m_axis_tvalid && !m_axis_tdata[21] |-> m_axis_tdata[20:0] <= 21'h10FFFF &&
		!(m_axis_tdata[20:0] >= 21'hD800 && m_axis_tdata[20:0] <= 21'hDFFF),
		"illegal code point delivered")

	`PUD_ASSERT(a_ready_when_flowing,
		!(m_axis_tvalid && !m_axis_tready) |-> s_axis_tready,
		"input stalled while output flows")

	`PUD_ASSERT(a_hold_on_stall,
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"stalled result changed")

endmodule

bind percent_utf8_decoder pud_checker u_pud_checker (.*);

### dv/code_point_checker.sv
`timescale 1ns / 1ps

module code_point_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [20:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          outstanding
);

	typedef enum logic [1:0] {
		STEP_NONE,
		STEP_CHAR,
		STEP_BAD
	} utf8_step_t;

	typedef struct packed {
		logic [pud_pkg::CP_W-1:0] code_point;
		logic                     is_error;
		logic                     last_out;
	} decoded_char_t;

	decoded_char_t            expected_chars[$];
	decoded_char_t            want;

	pud_pkg::esc_phase_t      esc;
	logic [3:0]               hi_digit;
	logic [pud_pkg::CP_W-1:0] accum;
	logic [1:0]               cont_left;
	logic [1:0]               cont_total;
	logic [pud_pkg::CP_W-1:0] cp_limit;

	initial mismatches = 0;

	function automatic void restart_decoder();
		esc = pud_pkg::ESC_NONE;
		hi_digit = '0;
		accum = '0;
		cont_left = '0;
		cont_total = '0;
	endfunction

	// 16 flags a non-hex character
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
		return 5'd16;
	endfunction

	function automatic utf8_step_t utf8_feed(input logic [7:0] b,
			output logic [pud_pkg::CP_W-1:0] cp);
		logic [pud_pkg::CP_W-1:0] v;
		cp = '0;
		if (cont_left == 0) begin
			if (b < 8'h80) begin
				v = {13'b0, b};
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				accum = {16'b0, b[4:0]};
				cont_left = 2'd1;
				cont_total = 2'd1;
				return STEP_NONE;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				accum = {17'b0, b[3:0]};
				cont_left = 2'd2;
				cont_total = 2'd2;
				return STEP_NONE;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				accum = {18'b0, b[2:0]};
				cont_left = 2'd3;
				cont_total = 2'd3;
				return STEP_NONE;
			end else begin
				return STEP_BAD;
			end
		end else begin
			if (b[7:6] != 2'b10) return STEP_BAD;
			accum = {accum[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left != 0) return STEP_NONE;
			v = accum;
			// overlong forms and surrogates
			if (cont_total == 2'd1 && v < 21'h80) return STEP_BAD;
			if (cont_total == 2'd2 && v < 21'h800) return STEP_BAD;
			if (cont_total == 2'd3 && v < 21'h10000) return STEP_BAD;
			if (v >= 21'hD800 && v <= 21'hDFFF) return STEP_BAD;
			accum = '0;
			cont_total = '0;
		end
		if (v > pud_pkg::UNICODE_MAX || v > cp_limit) return STEP_BAD;
		cp = v;
		return STEP_CHAR;
	endfunction

	function automatic void decode_enc_byte(input logic [7:0] b, input logic last);
		utf8_step_t               kind;
		logic [pud_pkg::CP_W-1:0] cp;
		logic [4:0]               h;
		kind = STEP_NONE;
		cp = '0;
		if (esc == pud_pkg::ESC_NONE) begin
			if (b == pud_pkg::PERCENT_CHAR) esc = pud_pkg::ESC_HI;
			else kind = utf8_feed(b, cp);
		end else begin
			h = hex_digit(b);
			if (h[4]) begin
				kind = STEP_BAD;
			end else if (esc == pud_pkg::ESC_HI) begin
				hi_digit = h[3:0];
				esc = pud_pkg::ESC_LO;
			end else begin
				esc = pud_pkg::ESC_NONE;
				kind = utf8_feed({hi_digit, h[3:0]}, cp);
				hi_digit = '0;
			end
		end
		// string ends inside an escape or a sequence
		if (kind == STEP_NONE && last && (esc != pud_pkg::ESC_NONE || cont_left != 0))
			kind = STEP_BAD;
		if (kind == STEP_CHAR) begin
			expected_chars.insert(expected_chars.size(), {cp, 1'b0, last});
		end else if (kind == STEP_BAD) begin
			expected_chars.insert(expected_chars.size(),
				{{pud_pkg::CP_W{1'b0}}, 1'b1, last});
			restart_decoder();
		end
		if (last) restart_decoder();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_limit = pud_pkg::MAX_CP_RESET;
			restart_decoder();
			expected_chars.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) cp_limit = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata[20:0] !== want.code_point) begin
						$error("code_point: expected %h, got %h", want.code_point,
							m_axis_tdata[20:0]);
						mismatches++;
					end
					if (m_axis_tdata[21] !== want.is_error) begin
						$error("is_error: expected %b, got %b", want.is_error, m_axis_tdata[21]);
						mismatches++;
					end
					if (m_axis_tlast !== want.last_out) begin
						$error("last_out: expected %b, got %b", want.last_out, m_axis_tlast);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) decode_enc_byte(s_axis_tdata, s_axis_tlast);
			outstanding <= expected_chars.size();
		end
	end

endmodule

### dv/tb_percent_utf8_decoder.sv
`timescale 1ns / 1ps

module tb_percent_utf8_decoder;

	localparam int IDLE_MAX       = 17;
	localparam int RANDOM_ITEMS   = 800;
	localparam int PHASES         = 5;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} enc_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [20:0] cfg_data = pud_pkg::MAX_CP_RESET;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	int          mismatches;
	int          outstanding;
	int          idle_cycles = 0;
	int          sent = 0;
	int          phase_start;
	bit          tx_calm = 1'b1;
	bit          rx_calm = 1'b1;
	bit          paused = 1'b0;
	logic [20:0] limit_value;
	enc_item_t   url_text[$];

	always #5 clk = ~clk;

	percent_utf8_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	code_point_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: one stall draw per transaction
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, IDLE_MAX);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + n;
		return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + n;
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		url_text.insert(url_text.size(), {b, 1'b0});
	endfunction

	function automatic void end_text();
		url_text[url_text.size() - 1].last = 1'b1;
	endfunction

	// raw '%' must always travel escaped
	function automatic void add_raw(input logic [7:0] b);
		if (b == pud_pkg::PERCENT_CHAR || $urandom_range(0, 2) == 0) begin
			add_byte(pud_pkg::PERCENT_CHAR);
			add_byte(hex_char(b[7:4]));
			add_byte(hex_char(b[3:0]));
		end else begin
			add_byte(b);
		end
	endfunction

	function automatic void add_char(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_raw(cp[7:0]);
		end else if (cp < 21'h800) begin
			add_raw({3'b110, cp[10:6]});
			add_raw({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			add_raw({4'b1110, cp[15:12]});
			add_raw({2'b10, cp[11:6]});
			add_raw({2'b10, cp[5:0]});
		end else begin
			add_raw({5'b11110, cp[20:18]});
			add_raw({2'b10, cp[17:12]});
			add_raw({2'b10, cp[11:6]});
			add_raw({2'b10, cp[5:0]});
		end
	endfunction

	function automatic logic [20:0] random_cp();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 21'($urandom_range(0, 'h7F));
			4, 5:       return 21'($urandom_range('h80, 'h7FF));
			6, 7:       return 21'($urandom_range('h800, 'hFFFF));
			8:          return 21'($urandom_range('h10000, 'h10FFFF));
			default:    return 21'($urandom_range('h10F000, 'h13FFFF));
		endcase
	endfunction

	function automatic void add_noise();
		logic [7:0] c;
		case ($urandom_range(0, 6))
			0: add_byte(8'($urandom_range(0, 255)));
			1: begin
				add_byte(pud_pkg::PERCENT_CHAR);
				if ($urandom_range(0, 1)) add_byte(hex_char(4'($urandom_range(0, 15))));
				do c = 8'($urandom_range(0, 255));
				while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
					(c >= 8'h61 && c <= 8'h66));
				add_byte(c);
			end
			2: begin
				case ($urandom_range(0, 2))
					0: begin
						add_raw(8'($urandom_range('hC0, 'hC1)));
					end
					1: begin
						add_raw(8'hE0);
						add_raw(8'($urandom_range('h80, 'h9F)));
					end
					default: begin
						add_raw(8'hF0);
						add_raw(8'($urandom_range('h80, 'h8F)));
						add_raw(8'($urandom_range('h80, 'hBF)));
					end
				endcase
				add_raw(8'($urandom_range('h80, 'hBF)));
			end
			3: begin
				add_raw(8'hED);
				add_raw(8'($urandom_range('hA0, 'hBF)));
				add_raw(8'($urandom_range('h80, 'hBF)));
			end
			4: begin
				add_raw(8'($urandom_range('hC2, 'hF4)));
				if ($urandom_range(0, 1)) add_raw(8'($urandom_range(0, 'h7F)));
				else add_raw(8'($urandom_range('hC0, 'hFF)));
			end
			5: begin
				if ($urandom_range(0, 1)) add_raw(8'($urandom_range('h80, 'hBF)));
				else add_raw(8'($urandom_range('hF5, 'hFF)));
			end
			default: add_byte(pud_pkg::PERCENT_CHAR);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic send_text();
		foreach (url_text[i]) send_byte(url_text[i].b, url_text[i].last);
		url_text.delete();
	endtask

	task automatic wait_until_quiet();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		// a byte that gives no result may still sit in the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cp_limit(input logic [20:0] v);
		wait_until_quiet();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic make_string();
		int n;
		n = $urandom_range(1, 10);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0) add_noise();
			else add_char(random_cp());
		end
		end_text();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain, escaped in both cases, bad hex, bad lead, bad continuation,
		// overlong, surrogate, largest code point, end inside escape and sequence
		add_byte(8'h41);
		add_byte(8'h00);
		add_byte(8'h7F);
		add_byte(8'h25); add_byte(8'h34); add_byte(8'h31);
		add_byte(8'h25); add_byte(8'h63); add_byte(8'h33);
		add_byte(8'h25); add_byte(8'h41); add_byte(8'h39);
		add_byte(8'h25); add_byte(8'h47);
		add_byte(8'hFF);
		add_byte(8'hE2); add_byte(8'h41);
		add_byte(8'hE0); add_byte(8'h80); add_byte(8'h80);
		add_byte(8'hED); add_byte(8'hA0); add_byte(8'h80);
		add_byte(8'hF4); add_byte(8'h8F); add_byte(8'hBF); add_byte(8'hBF);
		end_text();
		add_byte(8'h25);
		end_text();
		add_byte(8'hC3);
		end_text();
		send_text();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       limit_value = 21'd65535;
				2:       limit_value = 21'd1114111;
				default: limit_value = 21'($urandom_range(65535, 1114111));
			endcase
			write_cp_limit(limit_value);
			phase_start = sent;
			while (sent - phase_start < RANDOM_ITEMS / PHASES) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
				make_string();
				send_text();
				if (p == 1 && !paused && sent - phase_start >= RANDOM_ITEMS / 10) begin
					wait_until_quiet();
					paused = 1'b1;
				end
			end
		end

		wait_until_quiet();
		if (mismatches == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
